### src/addressed_frame_receiver_assert.svh
// Assertion macros for the addressed frame receiver.
// Each expects clk and rst in scope at the point of use.
`ifndef ADDRESSED_FRAME_RECEIVER_ASSERT_SVH
`define ADDRESSED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define AFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/afr_pkg.sv
package afr_pkg;

  localparam int HEADER_LEN = 5;
  localparam logic [7:0] STATION_RESET = 8'h09;

  typedef enum logic [1:0] {
    FN_BYTE    = 2'd0,
    FN_RELEASE = 2'd1,
    FN_READ    = 2'd2
  } afr_func_t;

  typedef enum logic [2:0] {
    ST_TAKEN    = 3'd0,
    ST_BUSY     = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_OTHER    = 3'd5
  } afr_status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_ADDR    = 2'd1,
    PH_PAYLOAD = 2'd3
  } afr_phase_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [4:0] read_index;
  } afr_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       frame_ready;
    logic [7:0] frame_function;
    logic [7:0] frame_extra;
    logic [7:0] payload_length;
    logic [7:0] frame_crc;
    logic [7:0] read_data;
  } afr_out_t;

  // Payload RAM access for one item; addresses are full byte positions,
  // the RAM keeps only the bits its depth needs.
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } afr_ram_req_t;

endpackage

### src/addressed_frame_receiver.sv
// Addressed frame receiver: slave side of a serial command link. Each transfer
// on the item channel is a received byte, a release of the held frame, or a
// read of one payload byte, and yields exactly one result transfer. The block
// takes one item per clock when the result side keeps up; a result appears in
// the cycle after its item is accepted, as both the read port of the payload
// RAM and the output register are registered. The RAM has one write and one
// read port; a byte write and a payload read never share an item, so no
// forwarding is needed. Write station_address only while the block is idle.
`include "addressed_frame_receiver_assert.svh"

module addressed_frame_receiver #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  afr_pkg::afr_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output afr_pkg::afr_out_t result,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data
);
  import afr_pkg::*;

  logic         accept;
  afr_out_t     res_d, res_q;
  afr_ram_req_t ram_req;
  logic [7:0]   rdata;
  logic         rd_sel;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  afr_frame_ctrl #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .res      (res_d),
    .ram_req  (ram_req)
  );

  afr_payload_ram #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // RAM read data is captured on the same edge as the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_q  <= res_d;
      rd_sel <= ram_req.re;
    end
  end

  always_comb begin
    result           = res_q;
    result.read_data = rd_sel ? rdata : 8'd0;
  end

  `AFR_ASSERT_NOW(a_stall_when_full, item_stall, result_valid && result_stall, "stall without pending result")
  `AFR_ASSERT_NEXT(a_item_gives_result, accept, result_valid, "accepted item produced no result")
  `AFR_ASSERT_NOW(a_complete_sets_ready, result_valid && (result.status == ST_COMPLETE), result.frame_ready, "complete without frame_ready")
  `AFR_ASSERT_NOW(a_read_data_only_other, result_valid && (result.read_data != 8'd0), result.status == ST_OTHER, "read data on non-read result")

endmodule

### src/afr_payload_ram.sv
module afr_payload_ram #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic                 clk,
  input  afr_pkg::afr_ram_req_t req,
  output logic [7:0]           rdata
);
  import afr_pkg::*;

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [7:0] mem [PAYLOAD_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule

### src/afr_frame_ctrl.sv
module afr_frame_ctrl #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  afr_pkg::afr_in_t      item,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_data,
  output afr_pkg::afr_out_t     res,
  output afr_pkg::afr_ram_req_t ram_req
);
  import afr_pkg::*;

  localparam logic [8:0] DEPTH_W = 9'(PAYLOAD_DEPTH);
  localparam logic [8:0] HDR_W   = 9'(HEADER_LEN);

  afr_phase_t  phase, phase_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [7:0]  hdr [HEADER_LEN];
  logic [7:0]  hdr_next [HEADER_LEN];
  logic [7:0]  crc, crc_next;
  logic        ready, ready_next;
  logic [7:0]  station_address;
  logic        hdr_we;
  afr_status_t status;

  logic [8:0] cnt_inc;
  logic       addr_ok;
  logic       size_zero;
  logic       last_byte;
  logic       pos_ok;
  logic       is_byte;

  assign cnt_inc   = byte_count + 9'd1;
  assign addr_ok   = (hdr[0] == station_address);
  assign size_zero = (hdr[3] == 8'd0);
  assign last_byte = (cnt_inc == ({1'b0, hdr[3]} + 9'd1));
  assign pos_ok    = (byte_count < DEPTH_W);
  assign is_byte   = (item.func == FN_BYTE) && !ready;

  // Next phase and byte count
  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    if (is_byte) begin
      unique case (phase)
        PH_HEADER: begin
          if (cnt_inc >= HDR_W) begin
            phase_next      = PH_ADDR;
            byte_count_next = '0;
          end else begin
            byte_count_next = cnt_inc;
          end
        end
        PH_ADDR: begin
          if (!addr_ok || size_zero) begin
            phase_next      = PH_HEADER;
            byte_count_next = '0;
          end else begin
            phase_next      = PH_PAYLOAD;
            byte_count_next = 9'd1;
          end
        end
        PH_PAYLOAD: begin
          if (last_byte) begin
            phase_next      = PH_HEADER;
            byte_count_next = '0;
          end else begin
            byte_count_next = cnt_inc;
          end
        end
        default: begin
          phase_next      = PH_HEADER;
          byte_count_next = '0;
        end
      endcase
    end
  end

  // Status, flags, header capture and RAM access
  always_comb begin
    status     = ST_OTHER;
    ready_next = ready;
    crc_next   = crc;
    hdr_we     = 1'b0;
    ram_req    = '0;
    ram_req.wdata = item.rx_byte;
    ram_req.waddr = byte_count[7:0];
    ram_req.raddr = {3'b000, item.read_index};
    unique case (item.func)
      FN_BYTE: begin
        if (ready) begin
          status = ST_BUSY;
        end else begin
          unique case (phase)
            PH_HEADER: begin
              status = ST_TAKEN;
              hdr_we = (byte_count < HDR_W);
            end
            PH_ADDR: begin
              if (!addr_ok) begin
                status = ST_MISMATCH;
              end else if (size_zero) begin
                status     = ST_COMPLETE;
                crc_next   = item.rx_byte;
                ready_next = 1'b1;
              end else begin
                // first payload byte lands at position zero
                ram_req.we = 1'b1;
                status     = ST_TAKEN;
              end
            end
            PH_PAYLOAD: begin
              ram_req.we = pos_ok;
              status     = pos_ok ? ST_TAKEN : ST_OVERFLOW;
              if (last_byte) begin
                status     = ST_COMPLETE;
                crc_next   = item.rx_byte;
                ready_next = 1'b1;
              end
            end
            default: status = ST_OTHER;
          endcase
        end
      end
      FN_RELEASE: ready_next = 1'b0;
      FN_READ:    ram_req.re = ({4'b0000, item.read_index} < DEPTH_W);
      default:    status = ST_OTHER;
    endcase
    // RAM only acts on the edge the item transfers
    ram_req.we = ram_req.we && accept;
    ram_req.re = ram_req.re && accept;
  end

  always_comb begin
    for (int i = 0; i < HEADER_LEN; i++) begin
      hdr_next[i] = (hdr_we && (byte_count[2:0] == 3'(i))) ? item.rx_byte : hdr[i];
    end
  end

  // Result reflects state after this item; read data joins in the top level.
  always_comb begin
    res.status         = status;
    res.frame_ready    = ready_next;
    res.frame_function = hdr_next[1];
    res.frame_extra    = hdr_next[2];
    res.payload_length = hdr_next[3];
    res.frame_crc      = crc_next;
    res.read_data      = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_count      <= '0;
      crc             <= '0;
      ready           <= 1'b0;
      station_address <= STATION_RESET;
      for (int i = 0; i < HEADER_LEN; i++) begin
        hdr[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        station_address <= cfg_data;
      end
      if (accept) begin
        phase      <= phase_next;
        byte_count <= byte_count_next;
        crc        <= crc_next;
        ready      <= ready_next;
        for (int i = 0; i < HEADER_LEN; i++) begin
          hdr[i] <= hdr_next[i];
        end
      end
    end
  end

endmodule
